[rtl/core/hsn_pkg.sv]
// hsn_pkg: shared types, constants and datapath command codes for the
// heightmap surface normal core; no dependencies
package hsn_pkg;

    localparam int GRID_SHORT_DEF = 256;
    localparam int GRID_LONG_DEF  = 256;
    localparam int CRD_W          = 13;       // wide enough for any grid coordinate + 1
    localparam logic [15:0] AMP_RESET = 16'd256;
    localparam int RT_STEPS       = 32;       // result bits of the square root
    localparam int DV_STEPS       = 15;       // quotient bits per component

    typedef struct packed {
        logic               func;
        logic        [7:0]  x_coord;
        logic        [7:0]  y_coord;
        logic signed [15:0] height;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [14:0] normal_z;
    } out_word_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRITE,
        OP_READ,
        OP_DIFF,
        OP_MULX,
        OP_MULY,
        OP_SCALE,
        OP_SQX,
        OP_SQY,
        OP_SQZ,
        OP_RT_INIT,
        OP_RT_STEP,
        OP_DV_INIT,
        OP_DV_STEP,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] rd_sel;   // 0 high x, 1 low x, 2 high y, 3 low y
        logic       cap;      // shift read data into the neighbor registers
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_write;
        logic out_full;
    } dp_status_t;

endpackage

[rtl/core/heightmap_surface_normal_core.sv]
// heightmap_surface_normal_core: top level, height grid with surface normal queries
// the core takes a new item only once the previous one is finished; a query runs 4 serial
//   memory reads, 32 square root steps and 15 divide steps, and waits to publish while the
//   result register is still full
// reset: aresetn synchronous active low; amplification returns to 1.0, height grid
//   keeps its contents and is undefined until written
module heightmap_surface_normal_core #(
    parameter int GRID_SHORT = hsn_pkg::GRID_SHORT_DEF,
    parameter int GRID_LONG  = hsn_pkg::GRID_LONG_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input word channel
    input  logic               s_valid,
    output logic               s_ready,
    input  hsn_pkg::in_word_t  s_data,
    // result word channel
    output logic               m_valid,
    input  logic               m_ready,
    output hsn_pkg::out_word_t m_data,
    // amplification register, unsigned Q8.8
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import hsn_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t st;

    // sequencer: accept, range check, read neighbors, multiply, root, divide, publish
    hsn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // datapath: grid memory, shared multiplier, root and divide lanes, output register
    hsn_datapath #(
        .GRID_SHORT (GRID_SHORT),
        .GRID_LONG  (GRID_LONG)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[rtl/core/hsn_ctrl.sv]
// hsn_ctrl: sequencing state machine of the surface normal core
// depends on hsn_pkg
module hsn_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hsn_pkg::dp_status_t st,
    output hsn_pkg::dp_cmd_t   cmd
);
    import hsn_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
        ST_DIFF, ST_MULX, ST_MULY, ST_SCALE, ST_SQX, ST_SQY, ST_SQZ,
        ST_RTI, ST_RT, ST_DVI, ST_DV, ST_PUB
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.rd_sel = 2'd0;
        cmd.cap    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!st.in_range) begin
                    state_next = ST_IDLE;
                end else if (st.is_write) begin
                    cmd.op     = OP_WRITE;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                cmd.op = OP_READ; cmd.rd_sel = 2'd0; state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.op = OP_READ; cmd.rd_sel = 2'd1; cmd.cap = 1'b1; state_next = ST_RD2;
            end
            ST_RD2: begin
                cmd.op = OP_READ; cmd.rd_sel = 2'd2; cmd.cap = 1'b1; state_next = ST_RD3;
            end
            ST_RD3: begin
                cmd.op = OP_READ; cmd.rd_sel = 2'd3; cmd.cap = 1'b1; state_next = ST_RD4;
            end
            ST_RD4: begin
                cmd.cap = 1'b1; state_next = ST_DIFF;
            end
            ST_DIFF:  begin cmd.op = OP_DIFF;  state_next = ST_MULX;  end
            ST_MULX:  begin cmd.op = OP_MULX;  state_next = ST_MULY;  end
            ST_MULY:  begin cmd.op = OP_MULY;  state_next = ST_SCALE; end
            ST_SCALE: begin cmd.op = OP_SCALE; state_next = ST_SQX;   end
            ST_SQX:   begin cmd.op = OP_SQX;   state_next = ST_SQY;   end
            ST_SQY:   begin cmd.op = OP_SQY;   state_next = ST_SQZ;   end
            ST_SQZ:   begin cmd.op = OP_SQZ;   state_next = ST_RTI;   end
            ST_RTI: begin
                cmd.op     = OP_RT_INIT;
                cnt_next   = 5'(RT_STEPS - 1);
                state_next = ST_RT;
            end
            ST_RT: begin
                cmd.op = OP_RT_STEP;
                if (cnt_reg == 5'd0) begin
                    state_next = ST_DVI;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_DVI: begin
                cmd.op     = OP_DV_INIT;
                cnt_next   = 5'(DV_STEPS - 1);
                state_next = ST_DV;
            end
            ST_DV: begin
                cmd.op = OP_DV_STEP;
                if (cnt_reg == 5'd0) begin
                    state_next = ST_PUB;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_PUB: begin
                if (!st.out_full) begin
                    cmd.op     = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_drop_out_of_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && !st.in_range) |=> (state_reg == ST_IDLE))
        else $error("out of grid item not dropped");
    a_root_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RT && cnt_reg == 5'd0) |=> (state_reg == ST_DVI))
        else $error("square root did not hand over to divide");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_PUBLISH) |-> !st.out_full)
        else $error("publish into full output register");

endmodule

[rtl/core/hsn_datapath.sv]
// hsn_datapath: height memory, multiplier, square root and divider lanes,
// output register; depends on hsn_pkg
module hsn_datapath #(
    parameter int GRID_SHORT = hsn_pkg::GRID_SHORT_DEF,
    parameter int GRID_LONG  = hsn_pkg::GRID_LONG_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hsn_pkg::in_word_t   s_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  hsn_pkg::dp_cmd_t    cmd,
    output hsn_pkg::dp_status_t st,
    output logic                m_valid,
    input  logic                m_ready,
    output hsn_pkg::out_word_t  m_data
);
    import hsn_pkg::*;

    localparam int DEPTH = GRID_SHORT * GRID_LONG;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CRD_W-1:0] XMAX = CRD_W'(GRID_SHORT - 1);
    localparam logic [CRD_W-1:0] YMAX = CRD_W'(GRID_LONG - 1);

    logic [15:0] mem [DEPTH];

    logic [15:0] amp_reg;
    in_word_t    item_reg;
    logic [15:0] rd_data_reg;
    logic [15:0] h_reg [4];

    logic [CRD_W-1:0] x, y, lx, hx, ly, hy, ax, ay;
    logic [1:0]       sx, sy;
    logic [AW-1:0]    addr;

    // neighbor coordinates, clamped at the grid edge
    always_comb begin
        x  = CRD_W'(item_reg.x_coord);
        y  = CRD_W'(item_reg.y_coord);
        lx = (x == '0) ? x : x - 1'b1;
        hx = (x == XMAX) ? x : x + 1'b1;
        ly = (y == '0) ? y : y - 1'b1;
        hy = (y == YMAX) ? y : y + 1'b1;
        sx = 2'(hx - lx);
        sy = 2'(hy - ly);
        ax = x;
        ay = y;
        if (cmd.op == OP_READ) begin
            case (cmd.rd_sel)
                2'd0:    ax = hx;
                2'd1:    ax = lx;
                2'd2:    ay = hy;
                default: ay = ly;
            endcase
        end
        // row times row length, computed at full address width
        addr = AW'(ay) * AW'(GRID_SHORT) + AW'(ax);
    end

    assign st.in_range = (x < CRD_W'(GRID_SHORT)) && (y < CRD_W'(GRID_LONG));
    assign st.is_write = (item_reg.func == FUNC_WRITE);

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE) begin
            mem[addr] <= item_reg.height;
        end
        rd_data_reg <= mem[addr];
    end

    // arithmetic
    logic signed [16:0] dzx, dzy;
    logic [15:0] absx_reg, absy_reg;
    logic        negx_reg, negy_reg;
    logic [32:0] mx_reg, my_reg, mz_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] acc_reg;
    logic [63:0] s_reg;
    logic [34:0] rem_reg, rem_t, trial;
    logic [31:0] root_reg, r;
    logic [46:0] dsh_reg;
    logic [46:0] dr_reg [3];
    logic [14:0] q_reg [3];
    logic [32:0] orv;

    assign dzx = {h_reg[3][15], h_reg[3]} - {h_reg[2][15], h_reg[2]};
    assign dzy = {h_reg[1][15], h_reg[1]} - {h_reg[0][15], h_reg[0]};

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd.op)
            OP_MULX: begin mul_a = {16'd0, amp_reg}; mul_b = {16'd0, absx_reg}; end
            OP_MULY: begin mul_a = {16'd0, amp_reg}; mul_b = {16'd0, absy_reg}; end
            OP_SQX:  begin mul_a = mx_reg[31:0]; mul_b = mx_reg[31:0]; end
            OP_SQY:  begin mul_a = my_reg[31:0]; mul_b = my_reg[31:0]; end
            OP_SQZ:  begin mul_a = mz_reg[31:0]; mul_b = mz_reg[31:0]; end
            default: ;
        endcase
    end
    assign prod  = mul_a * mul_b;
    assign orv   = mx_reg | my_reg | mz_reg;
    assign rem_t = {rem_reg[32:0], s_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign r     = (root_reg == 32'd0) ? 32'd1 : root_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            item_reg <= s_data;
        end
        if (cmd.cap) begin
            h_reg[3] <= h_reg[2];
            h_reg[2] <= h_reg[1];
            h_reg[1] <= h_reg[0];
            h_reg[0] <= rd_data_reg;
        end
        case (cmd.op)
            OP_DIFF: begin
                absx_reg <= dzx[16] ? 16'(-dzx) : dzx[15:0];
                absy_reg <= dzy[16] ? 16'(-dzy) : dzy[15:0];
                negx_reg <= !dzx[16] && (dzx != 17'sd0);
                negy_reg <= !dzy[16] && (dzy != 17'sd0);
                mz_reg   <= 33'({1'b0, sx} * {1'b0, sy}) << 20;
            end
            OP_MULX: mx_reg <= sy[1] ? {prod[31:0], 1'b0} : {1'b0, prod[31:0]};
            OP_MULY: my_reg <= sx[1] ? {prod[31:0], 1'b0} : {1'b0, prod[31:0]};
            OP_SCALE: begin
                if (orv[32]) begin
                    mx_reg <= mx_reg >> 2; my_reg <= my_reg >> 2; mz_reg <= mz_reg >> 2;
                end else if (orv[31]) begin
                    mx_reg <= mx_reg >> 1; my_reg <= my_reg >> 1; mz_reg <= mz_reg >> 1;
                end
            end
            OP_SQX: acc_reg <= prod;
            OP_SQY: acc_reg <= acc_reg + prod;
            OP_SQZ: acc_reg <= acc_reg + prod;
            OP_RT_INIT: begin
                s_reg    <= acc_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_RT_STEP: begin
                s_reg <= {s_reg[61:0], 2'b00};
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            OP_DV_INIT: begin
                dsh_reg   <= 47'({r, 1'b0}) << (DV_STEPS - 1);
                dr_reg[0] <= {1'b0, mx_reg[30:0], 15'd0} + 47'(r);
                dr_reg[1] <= {1'b0, my_reg[30:0], 15'd0} + 47'(r);
                dr_reg[2] <= {1'b0, mz_reg[30:0], 15'd0} + 47'(r);
                for (int i = 0; i < 3; i++) q_reg[i] <= '0;
            end
            OP_DV_STEP: begin
                dsh_reg <= dsh_reg >> 1;
                for (int i = 0; i < 3; i++) begin
                    if (dr_reg[i] >= dsh_reg) begin
                        dr_reg[i] <= dr_reg[i] - dsh_reg;
                        q_reg[i]  <= {q_reg[i][13:0], 1'b1};
                    end else begin
                        q_reg[i]  <= {q_reg[i][13:0], 1'b0};
                    end
                end
            end
            OP_PUBLISH: begin
                m_data.normal_x <= negx_reg ? 16'(-{1'b0, q_reg[0]}) : {1'b0, q_reg[0]};
                m_data.normal_y <= negy_reg ? 16'(-{1'b0, q_reg[1]}) : {1'b0, q_reg[1]};
                m_data.normal_z <= q_reg[2];
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg <= AMP_RESET;
            m_valid <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                amp_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_PUBLISH) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    assign st.out_full = m_valid;

endmodule

[verif/tb_heightmap_surface_normal_core.sv]
// tb_heightmap_surface_normal_core: self-checking testbench for the height grid
// surface normal core; depends on hsn_pkg and heightmap_surface_normal_core
module tb_heightmap_surface_normal_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hsn_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_data;
    logic       cfg_wr_en;
    logic [15:0] cfg_wr_data;

    heightmap_surface_normal_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // words waiting to be offered, normals waiting to come back
    in_word_t  pending_words[$];
    out_word_t expected_normals[$];

    // testbench copy of the grid and the gain
    logic [15:0] grid_heights [65536];
    logic [15:0] gain;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int stall_left;
    bit word_taken;
    int mismatches;
    int cycle_count;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] signed_component(input int d, input longint unsigned q);
        if (d > 0) return 16'(17'h10000 - 17'(q));
        if (d < 0) return 16'(q);
        return 16'd0;
    endfunction

    // central difference normal at (x, y) from the testbench grid copy
    function automatic out_word_t surface_normal(input logic [7:0] x, input logic [7:0] y);
        out_word_t nrm;
        logic [7:0] lx, hx, ly, hy;
        int sx, sy, dzx, dzy;
        longint unsigned mx, my, mz, r;
        lx = (x == 0) ? x : x - 8'd1;
        hx = (x == 8'd255) ? x : x + 8'd1;
        ly = (y == 0) ? y : y - 8'd1;
        hy = (y == 8'd255) ? y : y + 8'd1;
        sx = int'(hx) - int'(lx);
        sy = int'(hy) - int'(ly);
        dzx = int'($signed(grid_heights[{y, hx}])) - int'($signed(grid_heights[{y, lx}]));
        dzy = int'($signed(grid_heights[{hy, x}])) - int'($signed(grid_heights[{ly, x}]));
        mx = longint'(gain) * longint'(dzx < 0 ? -dzx : dzx) * longint'(sy);
        my = longint'(gain) * longint'(dzy < 0 ? -dzy : dzy) * longint'(sx);
        mz = longint'(sx * sy) << 20;
        // bring all magnitudes under 2^31
        while (((mx | my | mz) >> 31) != 0) begin
            mx >>= 1;
            my >>= 1;
            mz >>= 1;
        end
        r = floor_sqrt(mx * mx + my * my + mz * mz);
        if (r == 0) r = 1;
        nrm.normal_x = signed_component(dzx, ((mx << 15) + r) / (2 * r));
        nrm.normal_y = signed_component(dzy, ((my << 15) + r) / (2 * r));
        nrm.normal_z = 15'(((mz << 15) + r) / (2 * r));
        return nrm;
    endfunction

    // input side: accept, update grid copy, predict
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            word_taken = 1'b1;
            if (s_data.func == FUNC_WRITE) begin
                grid_heights[{s_data.y_coord, s_data.x_coord}] = s_data.height;
            end else begin
                expected_normals.push_back(surface_normal(s_data.x_coord, s_data.y_coord));
            end
        end
    end

    // driver: new word at the falling edge, held until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !word_taken) begin
            s_valid <= 1'b1;
        end else begin
            word_taken = 1'b0;
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off when one is requested
    always @(negedge aclk) begin
        if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin
        out_word_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_heightmap_surface_normal_core NOT OK");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            if (expected_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_data);
            end else begin
                want = expected_normals.pop_front();
                if (m_data.normal_x !== want.normal_x || m_data.normal_y !== want.normal_y
                        || m_data.normal_z !== want.normal_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("normal mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.normal_x, want.normal_y, want.normal_z,
                                 m_data.normal_x, m_data.normal_y, m_data.normal_z);
                end
            end
        end
    end

    task automatic push_word(input logic func, input logic [7:0] x, input logic [7:0] y,
                             input logic [15:0] h);
        in_word_t w;
        w.func = func;
        w.x_coord = x;
        w.y_coord = y;
        w.height = h;
        pending_words.push_back(w);
    endtask

    // coordinates lean toward the grid edges
    function automatic logic [7:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    // slope kinds: 0 random, 1 steepest rise, 2 steepest fall, 3 flat, 4 gentle
    function automatic logic [15:0] slope_height(input int kind, input bit high_side,
                                                 input logic [15:0] flat_val);
        case (kind)
            1: begin
                return high_side ? 16'h7fff : 16'h8000;
            end
            2: begin
                return high_side ? 16'h8000 : 16'h7fff;
            end
            3: begin
                return flat_val;
            end
            4: begin
                return 16'($urandom_range(0, 64) - 32);
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    // writes the cross of neighbors around (x, y), then queries it
    task automatic queue_patch(input logic [7:0] x, input logic [7:0] y, input int kind);
        logic [7:0] lx, hx, ly, hy;
        logic [15:0] flat_val;
        lx = (x == 0) ? x : x - 8'd1;
        hx = (x == 8'd255) ? x : x + 8'd1;
        ly = (y == 0) ? y : y - 8'd1;
        hy = (y == 8'd255) ? y : y + 8'd1;
        flat_val = 16'($urandom);
        push_word(FUNC_WRITE, lx, y, slope_height(kind, 1'b0, flat_val));
        push_word(FUNC_WRITE, hx, y, slope_height(kind, 1'b1, flat_val));
        push_word(FUNC_WRITE, x, ly, slope_height(kind, 1'b0, flat_val));
        push_word(FUNC_WRITE, x, hy, slope_height(kind, 1'b1, flat_val));
        // center only matters when it is its own neighbor at an edge
        if (lx == x || hx == x || ly == y || hy == y)
            push_word(FUNC_WRITE, x, y, slope_height(kind, 1'b0, flat_val));
        push_word(FUNC_QUERY, x, y, 16'($urandom));
    endtask

    // wait until the core is idle, then let in-flight writes finish
    task automatic wait_idle();
        while (pending_words.size() > 0 || s_valid || expected_normals.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        gain = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [15:0] centers_x[$];
        logic [15:0] centers_y[$];
        logic [15:0] phase_gain[4];
        int k, r, n, kind;
        logic [7:0] cx, cy;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        gain          = AMP_RESET;
        send_idle_pct = 20;
        recv_idle_pct = 86;
        stall_request = 0;
        stall_left    = 0;
        word_taken    = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: corners and a center cell at reset gain, steep and flat slopes
        queue_patch(8'd0, 8'd0, 1);
        queue_patch(8'd255, 8'd255, 2);
        queue_patch(8'd255, 8'd0, 3);
        queue_patch(8'd128, 8'd77, 1);
        wait_idle();

        phase_gain[0] = 16'd0;
        phase_gain[1] = 16'hffff;
        phase_gain[2] = 16'($urandom);
        phase_gain[3] = 16'($urandom_range(1, 1024));
        for (int ph = 0; ph < 4; ph++) begin
            write_gain(phase_gain[ph]);
            send_idle_pct = (ph < 1) ? 20 : (ph < 3) ? 86 : 0;
            recv_idle_pct = (ph < 1) ? 86 : (ph < 3) ? 20 : 0;
            if (ph == 2)
                stall_request = 400;
            n = 0;
            while (n < 95) begin
                r = $urandom_range(0, 99);
                k = pending_words.size();
                if (r < 70 || centers_x.size() == 0) begin
                    cx = pick_coord();
                    cy = pick_coord();
                    kind = $urandom_range(0, 9);
                    kind = (kind < 5) ? 0 : (kind < 7) ? 4 : kind - 6;
                    queue_patch(cx, cy, kind);
                    centers_x.push_back(cx);
                    centers_y.push_back(cy);
                end else if (r < 85) begin
                    // re-query an old cell whose neighbors are all written
                    k = $urandom_range(0, centers_x.size() - 1);
                    push_word(FUNC_QUERY, centers_x[k][7:0], centers_y[k][7:0],
                              16'($urandom));
                    k = pending_words.size() - 1;
                end else begin
                    // stray write anywhere
                    push_word(FUNC_WRITE, 8'($urandom), 8'($urandom), 16'($urandom));
                    k = pending_words.size() - 1;
                end
                n += pending_words.size() - k;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_heightmap_surface_normal_core OK");
        else
            $display("tb_heightmap_surface_normal_core NOT OK");
        $finish;
    end

endmodule

[heightmap_surface_normal_core.f]
rtl/core/hsn_pkg.sv
rtl/core/hsn_ctrl.sv
rtl/core/hsn_datapath.sv
rtl/core/heightmap_surface_normal_core.sv
verif/tb_heightmap_surface_normal_core.sv
